// File: sv/utjv_pkg.sv
// ----------------------------------------------------------------------------
// utjv_pkg - shared constants for the upwind transport voxel update
// register indexes, reset values and default widths
// ----------------------------------------------------------------------------
`default_nettype none

package utjv_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// configuration registers are Q0.16
	localparam int CFG_WIDTH = 16;

	localparam logic [CFG_WIDTH-1:0] DAMPING_RESET   = 16'd197;
	localparam logic [CFG_WIDTH-1:0] TOLERANCE_RESET = 16'd66;

	typedef enum logic [1:0] {
		REG_DAMPING   = 2'd0,
		REG_TOLERANCE = 2'd1
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/upwind_transport_jacobi_voxel.sv
// ----------------------------------------------------------------------------
// upwind_transport_jacobi_voxel - one voxel of an upwind jacobi sweep
// picks the upwind face neighbours, forms the weighted mean through a
// pipelined restoring divider, saturates and flags relative change
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         grad_*, value_*, centre_value, frozen
//  result    done (one cycle)     new_value, changed
//  config    cfg_we               cfg_index, cfg_data
//
//  a request is taken on every cycle with start high; busy never rises
//  a request passes through five set-up stages, one divider stage
//  per quotient bit, one saturation stage and the output register
//  reset clears the valid bits and loads the register defaults
//  results cannot be held off, so the pipeline never stalls
// ----------------------------------------------------------------------------
`default_nettype none

module upwind_transport_jacobi_voxel #(
	parameter int VALUE_WIDTH = utjv_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = utjv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  cfg_we,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [utjv_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  wire logic signed [VALUE_WIDTH-1:0]         grad_x,
	input  wire logic signed [VALUE_WIDTH-1:0]         grad_y,
	input  wire logic signed [VALUE_WIDTH-1:0]         grad_z,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_x_plus,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_x_minus,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_y_plus,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_y_minus,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_z_plus,
	input  wire logic signed [VALUE_WIDTH-1:0]         value_z_minus,
	input  wire logic signed [VALUE_WIDTH-1:0]         centre_value,
	input  wire logic                                  frozen,
	output logic                                       done,
	output logic signed [VALUE_WIDTH-1:0]              new_value,
	output logic                                       changed
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = utjv_pkg::CFG_WIDTH;
	localparam int PW = 2 * W;
	localparam int GW = W + 2;
	localparam int DW = ((W + CW + 1 > CW + FRAC_BITS) ? W + CW + 1 : CW + FRAC_BITS) + 1;
	localparam int NW = DW + W;
	localparam int TW = W + CW;
	// side data: frozen, centre sign, centre magnitude, centre raw
	localparam int S1W = 2 + 2 * W;
	// from stage two on the tolerance product rides along
	localparam int SW  = S1W + TW;

	logic [CW-1:0] damp_q;
	logic [CW-1:0] tol_q;
	logic [CW-1:0] damp_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q <= utjv_pkg::DAMPING_RESET;
			tol_q  <= utjv_pkg::TOLERANCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				utjv_pkg::REG_DAMPING:   damp_q <= cfg_data;
				utjv_pkg::REG_TOLERANCE: tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero damping would leave the divisor empty when all gradients are zero
	assign damp_eff = (damp_q == '0) ? CW'(1) : damp_q;
	assign busy     = 1'b0;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// ---------------- stage 1: magnitudes and upwind selection
	logic [W-1:0] g_in [3];
	logic [W-1:0] vp_in [3];
	logic [W-1:0] vm_in [3];
	logic [W-1:0] vsel [3];

	always_comb begin
		g_in[0] = grad_x;  vp_in[0] = value_x_plus;  vm_in[0] = value_x_minus;
		g_in[1] = grad_y;  vp_in[1] = value_y_plus;  vm_in[1] = value_y_minus;
		g_in[2] = grad_z;  vp_in[2] = value_z_plus;  vm_in[2] = value_z_minus;
		for (int a = 0; a < 3; a++) begin
			vsel[a] = (!g_in[a][W-1] && g_in[a] != '0) ? vp_in[a] : vm_in[a];
		end
	end

	logic           v_s1;
	logic [W-1:0]   gmag_s1 [3];
	logic [W-1:0]   vmag_s1 [3];
	logic           vneg_s1 [3];
	logic [S1W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			gmag_s1[a] <= mag(g_in[a]);
			vmag_s1[a] <= mag(vsel[a]);
			vneg_s1[a] <= vsel[a][W-1];
		end
		side_s1 <= {frozen, centre_value[W-1], mag(centre_value), centre_value};
	end

	// ---------------- stage 2: products and gradient sum
	logic          v_s2;
	logic [PW-1:0] prod_s2 [3];
	logic          vneg_s2 [3];
	logic [GW-1:0] gsum_s2;
	logic [SW-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			prod_s2[a] <= PW'(gmag_s1[a]) * PW'(vmag_s1[a]);
			vneg_s2[a] <= vneg_s1[a];
		end
		gsum_s2 <= GW'(gmag_s1[0]) + GW'(gmag_s1[1]) + GW'(gmag_s1[2]);
		side_s2 <= {side_s1, TW'(TW'(side_s1[2*W-1:W]) * TW'(tol_q))};
	end

	// ---------------- stage 3: signed sums and divisor
	logic          v_s3;
	logic [PW-1:0] pos_s3;
	logic [PW-1:0] neg_s3;
	logic [DW-1:0] den_s3;
	logic [SW-1:0] side_s3;
	logic [PW-1:0] pos_c;
	logic [PW-1:0] neg_c;

	always_comb begin
		pos_c = '0;
		neg_c = '0;
		for (int a = 0; a < 3; a++) begin
			if (vneg_s2[a]) neg_c = neg_c + prod_s2[a];
			else            pos_c = pos_c + prod_s2[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		pos_s3  <= pos_c;
		neg_s3  <= neg_c;
		den_s3  <= (DW'(gsum_s2) << CW) + (DW'(damp_eff) << FRAC_BITS);
		side_s3 <= side_s2;
	end

	// ---------------- stage 4: numerator magnitude
	logic          v_s4;
	logic [PW-1:0] num_s4;
	logic          rneg_s4;
	logic [DW-1:0] den_s4;
	logic [SW-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		rneg_s4 <= pos_s3 < neg_s3;
		num_s4  <= (pos_s3 < neg_s3) ? neg_s3 - pos_s3 : pos_s3 - neg_s3;
		den_s4  <= den_s3;
		side_s4 <= side_s3;
	end

	// ---------------- stage 5: overflow test, divider entry
	logic [NW-1:0] rem_div  [0:W-1];
	logic [DW-1:0] den_div  [0:W-1];
	logic [W-1:0]  q_div    [0:W];
	logic          ovf_div  [0:W];
	logic          rneg_div [0:W];
	logic          v_div    [0:W];
	logic [SW-1:0] side_div [0:W];
	logic [NW-1:0] num_al;

	// numerator moves to scale 2^(2F+16) to meet the Q0.16 damping
	assign num_al = NW'(num_s4) << CW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_div[0] <= 1'b0;
		else         v_div[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		rem_div[0]  <= num_al;
		den_div[0]  <= den_s4;
		q_div[0]    <= '0;
		ovf_div[0]  <= num_al >= (NW'(den_s4) << W);
		rneg_div[0] <= rneg_s4;
		side_div[0] <= side_s4;
	end

	// ---------------- divider: one quotient bit per stage, msb first
	for (genvar k = 1; k <= W; k++) begin : g_div
		logic [NW-1:0] trial;
		logic          hit;

		assign trial = NW'(den_div[k-1]) << (W - k);
		assign hit   = rem_div[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_div[k] <= 1'b0;
			else         v_div[k] <= v_div[k-1];
		end

		always_ff @(posedge clk) begin
			q_div[k]    <= q_div[k-1] | (W'(hit) << (W - k));
			ovf_div[k]  <= ovf_div[k-1];
			rneg_div[k] <= rneg_div[k-1];
			side_div[k] <= side_div[k-1];
		end

		if (k < W) begin : g_rem
			always_ff @(posedge clk) begin
				rem_div[k] <= hit ? rem_div[k-1] - trial : rem_div[k-1];
				den_div[k] <= den_div[k-1];
			end
		end
	end

	// ---------------- saturation and change magnitude
	logic [W-1:0]  lim;
	logic [W-1:0]  rmag;
	logic          rneg_f;
	logic          cneg_f;
	logic [W-1:0]  cmag_f;
	logic [W:0]    dmag_c;

	assign cneg_f = side_div[W][SW-2];
	assign cmag_f = side_div[W][TW+2*W-1:TW+W];
	assign lim    = rneg_div[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - 1'b1);
	assign rmag   = (ovf_div[W] || q_div[W] > lim) ? lim : q_div[W];
	assign rneg_f = rneg_div[W] && (rmag != '0);

	always_comb begin
		if (rneg_f == cneg_f) begin
			dmag_c = (rmag >= cmag_f) ? (W+1)'(rmag - cmag_f) : (W+1)'(cmag_f - rmag);
		end else begin
			dmag_c = (W+1)'(rmag) + (W+1)'(cmag_f);
		end
	end

	logic          v_sfin;
	logic [W-1:0]  res_sfin;
	logic [W:0]    dmag_sfin;
	logic          frozen_sfin;
	logic [W-1:0]  centre_sfin;
	logic [TW-1:0] ctol_sfin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sfin <= 1'b0;
		else         v_sfin <= v_div[W];
	end

	always_ff @(posedge clk) begin
		res_sfin    <= rneg_f ? (~rmag + 1'b1) : rmag;
		dmag_sfin   <= dmag_c;
		frozen_sfin <= side_div[W][SW-1];
		centre_sfin <= side_div[W][TW+W-1:TW];
		ctol_sfin   <= side_div[W][TW-1:0];
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_sfin;
	end

	always_ff @(posedge clk) begin
		if (frozen_sfin) begin
			new_value <= centre_sfin;
			changed   <= 1'b0;
		end else begin
			new_value <= res_sfin;
			changed   <= !((TW+1)'(ctol_sfin) >= ((TW+1)'(dmag_sfin) << CW));
		end
	end

endmodule

`default_nettype wire

// File: sv/utjv_checker.sv
// ----------------------------------------------------------------------------
// utjv_checker - port level checks for the voxel update pipeline
// fixed latency, no back-pressure, frozen pass-through and no flag on an unchanged value
// ----------------------------------------------------------------------------
`default_nettype none

module utjv_checker #(
	parameter int VALUE_WIDTH = utjv_pkg::VALUE_WIDTH_DEF,
	parameter int LATENCY     = utjv_pkg::VALUE_WIDTH_DEF + 7
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   frozen,
	input wire logic [VALUE_WIDTH-1:0] centre_value,
	input wire logic                   done,
	input wire logic [VALUE_WIDTH-1:0] new_value,
	input wire logic                   changed
);

	// the pipeline never refuses a request
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every result belongs to a request a fixed number of cycles back
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// frozen voxels return the centre and never report a change
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(frozen, LATENCY)) |->
		(new_value == $past(centre_value, LATENCY) && !changed))
		else $error("frozen voxel altered");

	// an unchanged value is never flagged
	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_value == $past(centre_value, LATENCY)) |-> !changed)
		else $error("change flagged on equal value");

endmodule

bind upwind_transport_jacobi_voxel utjv_checker #(
	.VALUE_WIDTH(VALUE_WIDTH),
	.LATENCY(VALUE_WIDTH + 7)
) u_utjv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.frozen(frozen),
	.centre_value(centre_value),
	.done(done),
	.new_value(new_value),
	.changed(changed)
);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for upwind_transport_jacobi_voxel
// directed table of corner requests, then random requests under several
// idling phases and register settings, each result compared with a listed or predicted value
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = utjv_pkg::VALUE_WIDTH_DEF;
	localparam int FB = utjv_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = VW + 7;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [VW-1:0] val_t;

	typedef struct packed {
		val_t gx, gy, gz;
		val_t xp, xm, yp, ym, zp, zm;
		val_t centre;
		logic frozen;
	} voxel_t;

	typedef struct packed {
		val_t value;
		logic chg;
	} update_t;

	typedef struct packed {
		voxel_t v;
		logic   known;
		update_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = utjv_pkg::REG_DAMPING;
	logic [utjv_pkg::CFG_WIDTH-1:0] cfg_data = '0;
	voxel_t drv = '0;
	logic done;
	val_t new_value;
	logic changed;

	logic [utjv_pkg::CFG_WIDTH-1:0] damping = utjv_pkg::DAMPING_RESET;
	logic [utjv_pkg::CFG_WIDTH-1:0] tolerance = utjv_pkg::TOLERANCE_RESET;
	update_t pending_updates[$];
	int errors = 0;
	int checked = 0;
	int idle_pct = 0;
	longint cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	upwind_transport_jacobi_voxel u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.grad_x(drv.gx), .grad_y(drv.gy), .grad_z(drv.gz),
		.value_x_plus(drv.xp), .value_x_minus(drv.xm),
		.value_y_plus(drv.yp), .value_y_minus(drv.ym),
		.value_z_plus(drv.zp), .value_z_minus(drv.zm),
		.centre_value(drv.centre), .frozen(drv.frozen),
		.done(done), .new_value(new_value), .changed(changed)
	);

	function automatic logic [VW-1:0] magnitude(val_t x);
		return x[VW-1] ? -x : x;
	endfunction

	// exact upwind mean, wide enough that nothing is lost before the divide
	function automatic update_t upwind_update(voxel_t v);
		update_t r;
		logic signed [127:0] acc, quot, res;
		logic [127:0] num, den, dmag;
		logic [VW:0] gsum;
		logic [VW-1:0] cmag;
		val_t g[3];
		val_t up[3];
		val_t dn[3];
		if (v.frozen) begin
			r.value = v.centre;
			r.chg = 1'b0;
			return r;
		end
		g = '{v.gx, v.gy, v.gz};
		up = '{v.xp, v.yp, v.zp};
		dn = '{v.xm, v.ym, v.zm};
		acc = 0;
		gsum = 0;
		for (int a = 0; a < 3; a++) begin
			acc += $signed({1'b0, magnitude(g[a])}) * ((!g[a][VW-1] && g[a] != 0) ? up[a] : dn[a]);
			gsum += magnitude(g[a]);
		end
		num = (acc < 0 ? -acc : acc) << 16;
		den = (128'(gsum) << 16) + (128'(damping == 0 ? 16'd1 : damping) << FB);
		quot = num / den;
		if (acc < 0) begin
			res = (quot > (128'(1) << (VW-1))) ? -(128'(1) << (VW-1)) : -quot;
		end else begin
			res = (quot > ((128'(1) << (VW-1)) - 1)) ? ((128'(1) << (VW-1)) - 1) : quot;
		end
		r.value = res[VW-1:0];
		dmag = res - 128'(v.centre);
		if (dmag[127]) dmag = -dmag;
		cmag = magnitude(v.centre);
		r.chg = !((128'(cmag) * tolerance) >= (dmag << 16));
		return r;
	endfunction

	// results are checked against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_updates.size() == 0) begin
				$error("unexpected result new_value=%h", new_value);
				errors++;
			end else begin
				update_t e;
				e = pending_updates.pop_front();
				checked++;
				if (new_value !== e.value) begin
					$error("new_value expected %h actual %h", e.value, new_value);
					errors++;
				end
				if (changed !== e.chg) begin
					$error("changed expected %b actual %b", e.chg, changed);
					errors++;
				end
			end
		end
	end

	// start stays high between back-to-back requests
	task automatic send_request(voxel_t v, logic known, update_t r);
		update_t e;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		e = upwind_update(v);
		if (known) e = r;
		drv <= v;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_updates = {pending_updates, e};
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		while (n < LATENCY + 4) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_reg(utjv_pkg::cfg_reg_t idx, logic [utjv_pkg::CFG_WIDTH-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == utjv_pkg::REG_DAMPING) damping = data;
		else tolerance = data;
	endtask

	function automatic val_t rand_val(int mode);
		case (mode)
			0: return val_t'($urandom);
			1: return val_t'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
			2: return $urandom_range(1) ? val_t'(32'h7fffffff) : val_t'(32'h80000000);
			default: return val_t'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
		endcase
	endfunction

	task automatic random_requests(int count);
		voxel_t v;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(9) < 6 ? 3 : $urandom_range(2);
			v.gx = rand_val($urandom_range(3) == 0 ? 1 : mode);
			v.gy = $urandom_range(7) == 0 ? val_t'(0) : rand_val(mode);
			v.gz = rand_val(mode);
			v.xp = rand_val(mode);
			v.xm = rand_val(mode);
			v.yp = rand_val(mode);
			v.ym = rand_val(mode);
			v.zp = rand_val(mode);
			v.zm = rand_val(mode);
			// centre near the neighbours now and then, so both flag values occur
			v.centre = $urandom_range(3) == 0 ? v.xm : rand_val(mode);
			v.frozen = $urandom_range(9) == 0;
			send_request(v, 1'b0, '0);
		end
	endtask

	localparam val_t MAXV = 32'h7fffffff;
	localparam val_t MINV = 32'h80000000;
	localparam val_t ONE  = 32'h00010000;

	row_t directed[] = '{
		'{'{ONE, ONE, ONE, ONE, 0, ONE, 0, ONE, 0, 0, 1'b1}, 1'b1, '{val_t'(0), 1'b0}},
		'{'{ONE, ONE, ONE, ONE, 0, ONE, 0, ONE, 0, MINV, 1'b1}, 1'b1, '{MINV, 1'b0}},
		'{'{0, 0, 0, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0, 1'b0}, 1'b1, '{val_t'(0), 1'b0}},
		'{'{0, 0, 0, 0, 0, 0, 0, 0, 0, MAXV, 1'b0}, 1'b1, '{val_t'(0), 1'b1}},
		'{'{ONE, ONE, ONE, MAXV, 0, MAXV, 0, MAXV, 0, 0, 1'b0}, 1'b0, '0},
		'{'{MINV, MINV, MINV, 0, MINV, 0, MINV, 0, MINV, 0, 1'b0}, 1'b0, '0},
		'{'{MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 1'b0}, 1'b0, '0},
		'{'{MINV, MAXV, 0, MAXV, MINV, MINV, MAXV, MAXV, MINV, MINV, 1'b0}, 1'b0, '0},
		'{'{val_t'(1), val_t'(-1), val_t'(1), ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, 1'b0}, 1'b0, '0},
		'{'{ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 1'b0}, 1'b0, '0},
		'{'{-ONE, -ONE, -ONE, 0, ONE, 0, ONE, 0, ONE, ONE, 1'b0}, 1'b0, '0},
		'{'{val_t'(1), 0, 0, MAXV, 0, 0, 0, 0, 0, MINV, 1'b0}, 1'b0, '0},
		'{'{val_t'(32'h5555aaaa), val_t'(32'haaaa5555), val_t'(32'h0f0f0f0f),
			val_t'(32'hf0f0f0f0), val_t'(32'h33333333), val_t'(32'hcccccccc),
			val_t'(32'h12345678), val_t'(32'hedcba987), val_t'(32'h7f00ff00),
			val_t'(32'h80ff00ff), 1'b0}, 1'b0, '0}
	};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i].v, directed[i].known, directed[i].r);
		drain();

		// setting, then idling per phase: none, 48 of a hundred, 7, none
		write_reg(utjv_pkg::REG_DAMPING, 16'd0);
		write_reg(utjv_pkg::REG_TOLERANCE, 16'd0);
		foreach (directed[i]) send_request(directed[i].v, 1'b0, '0);
		random_requests(100);
		drain();

		write_reg(utjv_pkg::REG_DAMPING, 16'hffff);
		write_reg(utjv_pkg::REG_TOLERANCE, 16'hffff);
		idle_pct = 48;
		random_requests(130);
		drain();

		write_reg(utjv_pkg::REG_DAMPING, 16'd1);
		write_reg(utjv_pkg::REG_TOLERANCE, 16'h0100);
		idle_pct = 7;
		random_requests(130);
		drain();

		write_reg(utjv_pkg::REG_DAMPING, utjv_pkg::DAMPING_RESET);
		write_reg(utjv_pkg::REG_TOLERANCE, utjv_pkg::TOLERANCE_RESET);
		idle_pct = 0;
		random_requests(100);
		drain();

		$display("covered %0d checked updates over four register settings", checked);
		$display("and idling of 0, 48 and 7 in a hundred cycles");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: upwind_transport_jacobi_voxel.f
sv/utjv_pkg.sv
sv/upwind_transport_jacobi_voxel.sv
sv/utjv_checker.sv
test/tb.sv
